### src/skq_pkg.sv
// shared types and constants for the sorted key queue
package skq_pkg;

    localparam int DefDepth        = 16;
    localparam int DefPayloadWidth = 32;
    localparam int KeyWidth        = 32;

    typedef enum logic [2:0] {
        K_PREPEND    = 3'd0,
        K_APPEND     = 3'd1,
        K_REMOVE_HD  = 3'd2,
        K_INSERT     = 3'd3,
        K_REMOVE_KEY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    localparam logic signed [KeyWidth-1:0] KeyMin = {1'b1, {(KeyWidth-1){1'b0}}};
    localparam logic signed [KeyWidth-1:0] KeyMax = {1'b0, {(KeyWidth-1){1'b1}}};

endpackage

### src/skq_ctrl.sv
// controller state machine of the sorted key queue
module skq_ctrl
    import skq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = i_in_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                o_cmd.load  = i_out_ready & i_in_valid;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_exec_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid) else $error("exec not followed by result");
    a_no_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.exec)) else $error("load during exec");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec) else $error("load not followed by exec");
`endif

endmodule

### src/skq_dp.sv
// datapath of the sorted key queue: cell array with compare and shift
module skq_dp
    import skq_pkg::*;
#(
    parameter int DEPTH         = DefDepth,
    parameter int PAYLOAD_WIDTH = DefPayloadWidth
)(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [2:0]                  i_kind,
    input  logic signed [KeyWidth-1:0]  i_key,
    input  logic [31:0]                 i_payload,
    output logic [1:0]                  o_status,
    output logic signed [KeyWidth-1:0]  o_key,
    output logic [31:0]                 o_payload
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [KeyWidth-1:0] r_keys [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]   r_pays [DEPTH];
    logic [CW-1:0]              r_count;
    logic [2:0]                 r_kind;
    logic signed [KeyWidth-1:0] r_key;
    logic [PAYLOAD_WIDTH-1:0]   r_pay;
    logic [1:0]                 r_status;
    logic signed [KeyWidth-1:0] r_kout;
    logic [31:0]                r_pout;

    logic [DEPTH-1:0] w_occ, w_gt, w_eq, w_before;
    logic [DEPTH-1:0] w_ins_sh, w_rem_sh, w_ins_at;
    logic             w_found;
    logic [IW-1:0]    w_fidx;
    logic             w_full, w_empty;
    logic signed [KeyWidth-1:0] w_head, w_tail, w_newkey;
    logic [1:0]       w_status;
    logic signed [KeyWidth-1:0] w_kout;
    logic [31:0]      w_pout;
    logic             w_do_ins, w_do_rem;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_head  = r_keys[0];
    assign w_tail  = r_keys[IW'(r_count - CW'(1))];

    // per-cell compares, then a prefix pass for the first match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_occ[i] = (CW'(i) < r_count);
            w_gt[i]  = w_occ[i] && (r_keys[i] > r_key);
            w_eq[i]  = w_occ[i] && (r_keys[i] == r_key);
        end
        w_before[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++) w_before[i] = w_before[i-1] | w_eq[i-1];
        w_found = |w_eq;
        w_fidx  = '0;
        for (int i = DEPTH - 1; i >= 0; i--) if (w_eq[i]) w_fidx = IW'(i);
    end

    always_comb begin
        w_status = ST_OK;
        w_kout   = '0;
        w_pout   = '0;
        w_newkey = '0;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_ins_sh = '0;
        w_ins_at = '0;
        w_rem_sh = '0;
        case (r_kind) inside
            K_PREPEND, K_APPEND, K_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_do_ins = 1'b1;
                    if (r_kind == K_PREPEND) begin
                        w_newkey = w_empty ? '0 : (w_head == KeyMin ? KeyMin : w_head - 1);
                        w_ins_sh = w_occ;
                    end else if (r_kind == K_APPEND) begin
                        w_newkey = w_empty ? '0 : (w_tail == KeyMax ? KeyMax : w_tail + 1);
                    end else begin
                        w_newkey = r_key;
                        w_ins_sh = w_gt;
                    end
                    w_kout = w_newkey;
                    // slot: lowest cell that moves up, else the first free cell
                    for (int i = 0; i < DEPTH; i++)
                        if (w_ins_sh[i] && (i == 0 || !w_ins_sh[(i == 0) ? 0 : i-1]))
                            w_ins_at[i] = 1'b1;
                    if (w_ins_sh == '0)
                        for (int i = 0; i < DEPTH; i++) w_ins_at[i] = (CW'(i) == r_count);
                end
            end
            K_REMOVE_HD, K_REMOVE_KEY: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (r_kind == K_REMOVE_HD) begin
                    w_do_rem = 1'b1;
                    w_kout   = r_keys[0];
                    w_pout   = 32'(r_pays[0]);
                    w_rem_sh = w_occ;
                end else if (!w_found) begin
                    w_status = ST_NOTFOUND;
                end else begin
                    w_do_rem = 1'b1;
                    w_kout   = r_keys[w_fidx];
                    w_pout   = 32'(r_pays[w_fidx]);
                    for (int i = 0; i < DEPTH; i++) w_rem_sh[i] = w_before[i] | w_eq[i];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (w_do_ins) r_count <= r_count + CW'(1);
            else if (w_do_rem) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_pay  <= PAYLOAD_WIDTH'(i_payload);
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_kout   <= w_kout;
            r_pout   <= w_pout;
            for (int i = 0; i < DEPTH; i++) begin
                if (w_do_ins) begin
                    // cells from the slot upward move up by one
                    if (w_ins_at[i]) begin
                        r_keys[i] <= w_newkey;
                        r_pays[i] <= r_pay;
                    end else if (i > 0 && w_ins_sh[(i == 0) ? 0 : i-1]) begin
                        r_keys[i] <= r_keys[(i == 0) ? 0 : i-1];
                        r_pays[i] <= r_pays[(i == 0) ? 0 : i-1];
                    end
                end else if (w_do_rem && i + 1 < DEPTH && w_rem_sh[i]
                             && w_occ[(i + 1) % DEPTH]) begin
                    r_keys[i] <= r_keys[(i + 1) % DEPTH];
                    r_pays[i] <= r_pays[(i + 1) % DEPTH];
                end
            end
        end
    end

    assign o_status  = r_status;
    assign o_key     = r_kout;
    assign o_payload = r_pout;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("count above depth");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_status == ST_FULL) |=> $stable(r_count))
        else $error("full insert changed count");
    a_ins_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_do_ins) |-> $onehot(w_ins_at)) else $error("insert slot not unique");
`endif

endmodule

### src/sorted_key_queue.sv
// sorted key queue: one operation per beat, parallel compare and shift cells
// each input beat is first loaded, then executed, and the result beat is sent from registers
// the queue works on one operation at a time: no new input beat is taken while one is in flight
// the next input beat is taken at the earliest in the cycle the result beat leaves
// reset: synchronous active low, empties the queue; cell contents are left as they are
module sorted_key_queue
    import skq_pkg::*;
#(
    parameter int DEPTH         = DefDepth,
    parameter int PAYLOAD_WIDTH = DefPayloadWidth
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,  // kind
    input  logic [63:0] s_axis_tdata,  // key_in[31:0], payload_in[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // status[1:0], key_out[33:2], payload_out[65:34], zero
);

    t_cmd w_cmd;
    logic [1:0]  w_status;
    logic [31:0] w_key, w_pay;

    skq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    skq_dp #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_kind    (s_axis_tuser),
        .i_key     (s_axis_tdata[31:0]),
        .i_payload (s_axis_tdata[63:32]),
        .o_status  (w_status),
        .o_key     (w_key),
        .o_payload (w_pay)
    );

    assign m_axis_tdata = {6'd0, w_pay, w_key, w_status};

endmodule

### test/skq_checker.sv
// checker for the sorted key queue: models the queue and compares every result beat
module skq_checker
    import skq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key;
        logic [31:0] payload;
    } t_result;

    logic signed [31:0] q_keys[$];
    logic [31:0]        q_pays[$];
    t_result            expected_results[$];

    function automatic t_result apply_op(logic [2:0] kind, logic signed [31:0] key,
                                         logic [31:0] pay);
        t_result r;
        int idx;
        r = '0;
        case (kind)
            K_PREPEND, K_APPEND, K_INSERT: begin
                if (q_keys.size() >= DefDepth) begin
                    r.status = ST_FULL;
                end else if (kind == K_PREPEND) begin
                    if (q_keys.size() > 0)
                        r.key = (q_keys[0] == KeyMin) ? KeyMin : q_keys[0] - 1;
                    q_keys.push_front(r.key);
                    q_pays.push_front(pay);
                end else if (kind == K_APPEND) begin
                    if (q_keys.size() > 0)
                        r.key = (q_keys[$] == KeyMax) ? KeyMax : q_keys[$] + 1;
                    q_keys.push_back(r.key);
                    q_pays.push_back(pay);
                end else begin
                    // goes after any equal keys
                    idx = 0;
                    while (idx < q_keys.size() && q_keys[idx] <= key) idx++;
                    r.key = key;
                    q_keys.insert(idx, key);
                    q_pays.insert(idx, pay);
                end
            end
            K_REMOVE_HD, K_REMOVE_KEY: begin
                if (q_keys.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx = 0;
                    if (kind == K_REMOVE_KEY)
                        while (idx < q_keys.size() && q_keys[idx] != key) idx++;
                    if (idx >= q_keys.size()) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.key = q_keys[idx];
                        r.payload = q_pays[idx];
                        q_keys.delete(idx);
                        q_pays.delete(idx);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            q_keys.delete();
            q_pays.delete();
            expected_results.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = m_axis_tdata[1:0];
                got.key     = m_axis_tdata[33:2];
                got.payload = m_axis_tdata[65:34];
                o_results_seen <= o_results_seen + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status || got.key != want.key
                            || got.payload != want.payload) begin
                        $display("%0t: mismatch expected st=%0d key=%h pay=%h got st=%0d key=%h pay=%h",
                                 $time, want.status, want.key, want.payload,
                                 got.status, got.key, got.payload);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_op(s_axis_tuser, s_axis_tdata[31:0],
                                                    s_axis_tdata[63:32]));
        end
    end

endmodule

### test/tb.sv
// testbench top: stimulus, receiver stalls and verdict for the sorted key queue
module tb;
    import skq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    int          fail_count, pending, results_seen;
    int          idle_cycles = 0;
    int          ops_sent = 0;
    bit          hold_off = 1'b0;
    bit          stall_done = 1'b0;

    always #10 i_clk = ~i_clk;

    sorted_key_queue dut (.*);

    skq_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // receiver: random backpressure, plus one long hold-off while the queue fills
    always @(posedge i_clk) begin
        int n;
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            n = $urandom_range(0, 3);
            m_axis_tready <= (n != 0);
        end
    end

    initial begin
        repeat (200) @(posedge i_clk);
        wait (ops_sent > 300);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off = 1'b0;
        stall_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("watchdog expired at %0t", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_op(logic [2:0] kind, logic [31:0] key, logic [31:0] pay, bit no_gap);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {pay, key};
        do @(posedge i_clk); while (!s_axis_tready);
        ops_sent++;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic finish_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 4;
            1: return KeyMin + $urandom_range(0, 2);
            2: return KeyMax - $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [2:0] kind;
        int r;
        bit burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty cases, saturation at both ends, full queue, unused kinds
        send_op(K_REMOVE_HD, '0, '0, 0);
        send_op(K_REMOVE_KEY, 32'd5, '0, 0);
        send_op(K_PREPEND, '0, 32'hFFFF_FFFF, 0);
        send_op(K_APPEND, '0, 32'h0, 0);
        send_op(K_REMOVE_KEY, 32'd7, '0, 0);
        send_op(K_INSERT, KeyMin, 32'hA5A5_5A5A, 0);
        send_op(K_PREPEND, '0, 32'h1234_5678, 0);
        send_op(K_INSERT, KeyMax, 32'h8000_0001, 0);
        send_op(K_APPEND, '0, 32'h7FFF_FFFE, 0);
        send_op(K_INSERT, KeyMax, 32'h1, 0);
        send_op(K_REMOVE_KEY, KeyMin, '0, 0);
        send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_op(3'd7, '0, '0, 0);
        send_op(K_REMOVE_KEY, KeyMax, '0, 0);
        for (int i = 0; i < 12; i++) send_op(K_INSERT, 32'd3, i, 1);
        send_op(K_APPEND, '0, 32'hDEAD_BEEF, 0);
        send_op(K_PREPEND, '0, 32'hBEEF_DEAD, 0);

        // random: mix weighted to move the fill level around, bursts with no gaps
        for (int i = 0; i < 700; i++) begin
            r = $urandom_range(0, 99);
            if (i < 250 || i > 450)
                kind = (r < 15) ? K_PREPEND : (r < 30) ? K_APPEND : (r < 48) ? K_REMOVE_HD
                     : (r < 70) ? K_INSERT : (r < 97) ? K_REMOVE_KEY : 3'($urandom_range(5, 7));
            else
                kind = (r < 60) ? K_INSERT : (r < 80) ? K_APPEND : K_REMOVE_KEY;
            burst = (i % 80) < 20;
            send_op(kind, pick_key(), $urandom, burst);
            if (i == 350) begin
                // pause until the queue has answered everything
                finish_sending();
                wait (pending == 0);
            end
        end
        finish_sending();
        wait (stall_done);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);

        $display("sent %0d operations, checked %0d results, with input and output stalls",
                 ops_sent, results_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
